### src/tld_pkg.sv
package tld_pkg;

  localparam int KEY_W      = 8;
  localparam int GROUP_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Special key codes.
  localparam logic [KEY_W-1:0] KEY_CTRL_C = 8'h03;
  localparam logic [KEY_W-1:0] KEY_CTRL_Q = 8'h11;
  localparam logic [KEY_W-1:0] KEY_CTRL_Z = 8'h1A;
  localparam logic [KEY_W-1:0] KEY_BS     = 8'h08;
  localparam logic [KEY_W-1:0] KEY_NL     = 8'h0A;
  localparam logic [KEY_W-1:0] KEY_SP     = 8'h20;

  // Result destinations.
  localparam logic [1:0] DEST_ECHO   = 2'd0;
  localparam logic [1:0] DEST_READER = 2'd1;
  localparam logic [1:0] DEST_SIGNAL = 2'd2;

  // Signal kinds.
  localparam logic [1:0] SIG_INT  = 2'd0;
  localparam logic [1:0] SIG_CONT = 2'd1;
  localparam logic [1:0] SIG_STOP = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANONICAL_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_GROUP  = 2'd2;

  typedef struct packed {
    logic               echo_enable;
    logic               canonical_mode;
    logic [GROUP_W-1:0] process_group;
  } cfg_t;

endpackage

### src/tld_if.sv
interface tld_key_if;
  import tld_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_byte;

  modport source (output valid, output key_byte, input ready);
  modport sink (input valid, input key_byte, output ready);
endinterface

interface tld_res_if;
  import tld_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         destination;
  logic [KEY_W-1:0]   data_byte;
  logic [1:0]         signal_kind;
  logic [GROUP_W-1:0] signal_group;
  logic               last;

  modport source (output valid, output destination, output data_byte, output signal_kind,
                  output signal_group, output last, input ready);
  modport sink (input valid, input destination, input data_byte, input signal_kind,
                input signal_group, input last, output ready);
endinterface

interface tld_cfg_if;
  import tld_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

### src/tld_line_ram.sv
module tld_line_ram #(
  parameter int LINE_DEPTH = 32,
  parameter int AW         = 5
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [tld_pkg::KEY_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [tld_pkg::KEY_W-1:0] rd_data
);
  import tld_pkg::*;

  logic [KEY_W-1:0] mem [LINE_DEPTH];
  logic [KEY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### src/tld_ctrl.sv
module tld_ctrl #(
  parameter int LINE_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tld_pkg::cfg_t cfg,
  tld_key_if.sink       in_key,
  tld_res_if.source     out_res
);
  import tld_pkg::*;

  localparam int CW = $clog2(LINE_DEPTH + 1);
  localparam int AW = $clog2(LINE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(LINE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ECHO  = 3'd1;
  localparam logic [2:0] ST_SIG   = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [CW-1:0]      flush_len_r, flush_len_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [1:0]         echo_pos_r, echo_pos_nxt;
  logic               erase_r, erase_nxt;
  logic               sig_r, sig_nxt;
  logic [1:0]         kind_r, kind_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         dest_r, dest_nxt;
  logic [KEY_W-1:0]   data_r, data_nxt;
  logic [1:0]         okind_r, okind_nxt;
  logic [GROUP_W-1:0] group_r, group_nxt;
  logic               last_r, last_nxt;

  logic               accept;
  logic               slot_free;
  logic               emit;
  logic [1:0]         em_dest;
  logic [KEY_W-1:0]   em_data;
  logic [1:0]         em_kind;
  logic [GROUP_W-1:0] em_group;
  logic               em_last;

  logic [KEY_W-1:0]   c;
  logic               erase, trig, has_sig, has_echo;
  logic [1:0]         kind;
  logic [CW-1:0]      new_fill;
  logic [2:0]         after_sig;

  logic               ram_wr_en;
  logic [KEY_W-1:0]   ram_rd_data;

  assign accept    = in_key.valid && in_key.ready;
  assign slot_free = !out_valid_r || out_res.ready;
  assign c         = in_key.key_byte;

  // Decode of the incoming word.
  always_comb begin
    erase    = cfg.canonical_mode && (c == KEY_BS);
    has_sig  = (c == KEY_CTRL_C) || (c == KEY_CTRL_Q) || (c == KEY_CTRL_Z);
    trig     = has_sig || (c == KEY_NL) || !cfg.canonical_mode;
    has_echo = cfg.echo_enable && (!erase || (fill_r != '0));
    priority if (c == KEY_CTRL_Q) begin
      kind = SIG_CONT;
    end else if (c == KEY_CTRL_Z) begin
      kind = SIG_STOP;
    end else begin
      kind = SIG_INT;
    end
    if (erase) begin
      new_fill = (fill_r != '0) ? fill_r - ONE_C : fill_r;
    end else begin
      new_fill = (fill_r < DEPTH_C) ? fill_r + ONE_C : fill_r;
    end
    ram_wr_en = accept && !erase && (fill_r < DEPTH_C);
  end

  tld_line_ram #(
    .LINE_DEPTH (LINE_DEPTH),
    .AW         (AW)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data (c),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  // Sequencer: one result word per step, all through the single output register.
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    flush_len_nxt = flush_len_r;
    idx_nxt       = idx_r;
    echo_pos_nxt  = echo_pos_r;
    erase_nxt     = erase_r;
    sig_nxt       = sig_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    emit          = 1'b0;
    em_dest       = DEST_ECHO;
    em_data       = '0;
    em_kind       = SIG_INT;
    em_group      = '0;
    em_last       = 1'b0;
    after_sig     = (flush_len_r != '0) ? ST_WAIT : ST_IDLE;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          key_nxt       = c;
          erase_nxt     = erase;
          sig_nxt       = has_sig;
          kind_nxt      = kind;
          echo_pos_nxt  = '0;
          idx_nxt       = '0;
          flush_len_nxt = trig ? new_fill : '0;
          fill_nxt      = trig ? '0 : new_fill;
          priority if (has_echo) begin
            state_nxt = ST_ECHO;
          end else if (has_sig) begin
            state_nxt = ST_SIG;
          end else if (trig && (new_fill != '0)) begin
            state_nxt = ST_WAIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ECHO: begin
        emit    = slot_free;
        em_dest = DEST_ECHO;
        if (erase_r) begin
          em_data = (echo_pos_r == 2'd1) ? KEY_SP : KEY_BS;
        end else begin
          em_data = key_r;
        end
        em_last = (!erase_r || (echo_pos_r == 2'd2)) && !sig_r && (flush_len_r == '0);
        if (emit) begin
          if (erase_r && (echo_pos_r != 2'd2)) begin
            echo_pos_nxt = echo_pos_r + 2'd1;
          end else if (sig_r) begin
            state_nxt = ST_SIG;
          end else begin
            state_nxt = after_sig;
          end
        end
      end
      ST_SIG: begin
        emit     = slot_free;
        em_dest  = DEST_SIGNAL;
        em_kind  = kind_r;
        em_group = cfg.process_group;
        em_last  = (flush_len_r == '0);
        if (emit) begin
          state_nxt = after_sig;
        end
      end
      ST_WAIT: begin
        // The line memory read of idx_r lands at the next edge.
        state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        emit    = slot_free;
        em_dest = DEST_READER;
        em_data = ram_rd_data;
        em_last = (idx_r == flush_len_r - ONE_C);
        if (emit) begin
          if (em_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + ONE_C;
            state_nxt = ST_WAIT;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = emit || (out_valid_r && !out_res.ready);
    dest_nxt      = emit ? em_dest  : dest_r;
    data_nxt      = emit ? em_data  : data_r;
    okind_nxt     = emit ? em_kind  : okind_r;
    group_nxt     = emit ? em_group : group_r;
    last_nxt      = emit ? em_last  : last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      flush_len_r <= '0;
      idx_r       <= '0;
      echo_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      flush_len_r <= flush_len_nxt;
      idx_r       <= idx_nxt;
      echo_pos_r  <= echo_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    erase_r <= erase_nxt;
    sig_r   <= sig_nxt;
    kind_r  <= kind_nxt;
    key_r   <= key_nxt;
    dest_r  <= dest_nxt;
    data_r  <= data_nxt;
    okind_r <= okind_nxt;
    group_r <= group_nxt;
    last_r  <= last_nxt;
  end

  assign in_key.ready         = (state_r == ST_IDLE);
  assign out_res.valid        = out_valid_r;
  assign out_res.destination  = dest_r;
  assign out_res.data_byte    = data_r;
  assign out_res.signal_kind  = okind_r;
  assign out_res.signal_group = group_r;
  assign out_res.last         = last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= DEPTH_C) && (flush_len_r <= DEPTH_C))
    else $error("line fill count exceeds the line depth");

  a_idx_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_WAIT) || (state_r == ST_FLUSH)) |-> (idx_r < flush_len_r))
    else $error("flush read index outside the delivered line");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && em_last) |=> (state_r == ST_IDLE))
    else $error("sequencer kept running after the final word of an item");

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && trig) |=> (fill_r == '0))
    else $error("line not emptied on delivery");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !em_last) |=> !in_key.ready)
    else $error("new word accepted before the current item finished");

endmodule

### src/tty_line_discipline.sv
// Channel   Port     Direction  Payload
// key in    in_key   sink       key_byte
// result    out_res  source     destination, data_byte, signal_kind, signal_group, last
// config    cfg_wr   sink       reg_index, wr_data (always ready)
//
// One input word is accepted while idle, then yields its echo words (0, 1 or 3),
// a signal event for a signal key, and the delivered line bytes, each read in a wait
// step before it is sent. The line memory's single registered read port
// and the one output register set the flush pace. in_key.ready is low while a word
// is in progress; a stalled result holds the sequencer in place. Synchronous reset
// empties the line and restores the register defaults; no clearing pass is needed.
module tty_line_discipline #(
  parameter int LINE_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  tld_key_if.sink   in_key,
  tld_res_if.source out_res,
  tld_cfg_if.sink   cfg_wr
);
  import tld_pkg::*;

  logic               echo_enable_r, echo_enable_nxt;
  logic               canonical_mode_r, canonical_mode_nxt;
  logic [GROUP_W-1:0] process_group_r, process_group_nxt;
  cfg_t               cfg;

  always_comb begin
    echo_enable_nxt    = echo_enable_r;
    canonical_mode_nxt = canonical_mode_r;
    process_group_nxt  = process_group_r;
    if (cfg_wr.valid) begin
      unique case (cfg_wr.reg_index)
        CFG_ECHO_ENABLE:    echo_enable_nxt    = cfg_wr.wr_data[0];
        CFG_CANONICAL_MODE: canonical_mode_nxt = cfg_wr.wr_data[0];
        CFG_PROCESS_GROUP:  process_group_nxt  = cfg_wr.wr_data[GROUP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_enable_r    <= 1'b1;
      canonical_mode_r <= 1'b1;
      process_group_r  <= '0;
    end else begin
      echo_enable_r    <= echo_enable_nxt;
      canonical_mode_r <= canonical_mode_nxt;
      process_group_r  <= process_group_nxt;
    end
  end

  assign cfg_wr.ready       = 1'b1;
  assign cfg.echo_enable    = echo_enable_r;
  assign cfg.canonical_mode = canonical_mode_r;
  assign cfg.process_group  = process_group_r;

  tld_ctrl #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_key  (in_key),
    .out_res (out_res)
  );

endmodule

### tb/tb_tty_line_discipline.sv
module tb_tty_line_discipline;
  timeunit 1ns;
  timeprecision 1ps;

  import tld_pkg::*;

  localparam int LINE_DEPTH    = 32;
  localparam int SETTLE_CYCLES = 2 * LINE_DEPTH + 16;
  localparam int LONG_HOLD     = 300;
  localparam int PHASES        = 10;
  localparam int PHASE_KEYS    = 32;
  localparam int DIR_ROWS      = 28;

  // Index that maps to no register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct packed {
    logic [1:0]         destination;
    logic [KEY_W-1:0]   data_byte;
    logic [1:0]         signal_kind;
    logic [GROUP_W-1:0] signal_group;
    logic               last;
  } res_word_t;

  typedef enum logic [1:0] {ROW_KEY, ROW_KEY_FIXED, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] value;
    logic                  fixed_count;
    res_word_t             fixed_word;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tld_key_if key_if ();
  tld_res_if res_if ();
  tld_cfg_if cfg_if ();

  tty_line_discipline #(.LINE_DEPTH(LINE_DEPTH)) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_key  (key_if),
    .out_res (res_if),
    .cfg_wr  (cfg_if)
  );

  always #10 clk = ~clk;

  // Shadow state of the line discipline.
  logic [KEY_W-1:0] line_copy [LINE_DEPTH];
  int               line_fill;
  cfg_t             cur_cfg;

  res_word_t expected_words [$];
  int        error_count;
  int        keys_sent;
  bit        idle_on;
  bit        long_hold_req;

  function automatic void push_word(input logic [1:0] dest, input logic [KEY_W-1:0] data,
                                    input logic [1:0] kind, input logic [GROUP_W-1:0] group);
    res_word_t w;
    w.destination  = dest;
    w.data_byte    = data;
    w.signal_kind  = kind;
    w.signal_group = group;
    w.last         = 1'b0;
    expected_words.push_back(w);
  endfunction

  // Appends the words one typed byte causes and returns how many there are.
  function automatic int predict_key(input logic [KEY_W-1:0] k);
    int        base;
    logic      canon;
    logic      erase;
    res_word_t w;
    base  = expected_words.size();
    canon = cur_cfg.canonical_mode;
    erase = canon && (k == KEY_BS);
    if (cur_cfg.echo_enable) begin
      if (erase) begin
        if (line_fill > 0) begin
          push_word(DEST_ECHO, KEY_BS, SIG_INT, '0);
          push_word(DEST_ECHO, KEY_SP, SIG_INT, '0);
          push_word(DEST_ECHO, KEY_BS, SIG_INT, '0);
        end
      end else begin
        push_word(DEST_ECHO, k, SIG_INT, '0);
      end
    end
    if (erase) begin
      if (line_fill > 0) line_fill--;
    end else if (line_fill < LINE_DEPTH) begin
      line_copy[line_fill] = k;
      line_fill++;
    end
    if (k == KEY_NL || k == KEY_CTRL_C || k == KEY_CTRL_Q || k == KEY_CTRL_Z || !canon) begin
      if (k == KEY_CTRL_C) push_word(DEST_SIGNAL, '0, SIG_INT, cur_cfg.process_group);
      else if (k == KEY_CTRL_Q) push_word(DEST_SIGNAL, '0, SIG_CONT, cur_cfg.process_group);
      else if (k == KEY_CTRL_Z) push_word(DEST_SIGNAL, '0, SIG_STOP, cur_cfg.process_group);
      for (int i = 0; i < line_fill; i++) push_word(DEST_READER, line_copy[i], SIG_INT, '0);
      line_fill = 0;
    end
    if (expected_words.size() > base) begin
      w = expected_words.pop_back();
      w.last = 1'b1;
      expected_words.push_back(w);
    end
    return expected_words.size() - base;
  endfunction

  function automatic dir_row_t key_row(input logic [KEY_W-1:0] k);
    dir_row_t r;
    r = '0;
    r.kind  = ROW_KEY;
    r.value = {{(CFG_DATA_W - KEY_W){1'b0}}, k};
    return r;
  endfunction

  // A key whose outcome is written out here: no word at all, or one word
  // carrying the key itself.
  function automatic dir_row_t fixed_row(input logic [KEY_W-1:0] k, input logic cnt,
                                         input logic [1:0] dest);
    dir_row_t r;
    r = key_row(k);
    r.kind                    = ROW_KEY_FIXED;
    r.fixed_count             = cnt;
    r.fixed_word.destination  = dest;
    r.fixed_word.data_byte    = k;
    r.fixed_word.signal_kind  = SIG_INT;
    r.fixed_word.signal_group = '0;
    r.fixed_word.last         = 1'b1;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    dir_row_t r;
    r = '0;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.value   = val;
    return r;
  endfunction

  // Drops the key valid and waits until the block has drained.
  task automatic settle();
    key_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wr_data   <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_ECHO_ENABLE:    cur_cfg.echo_enable = val[0];
      CFG_CANONICAL_MODE: cur_cfg.canonical_mode = val[0];
      CFG_PROCESS_GROUP:  cur_cfg.process_group = val[GROUP_W-1:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_key(input logic [KEY_W-1:0] k, output int n_words);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      key_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    key_if.valid    <= 1'b1;
    key_if.key_byte <= k;
    do @(posedge clk); while (!key_if.ready);
    n_words = predict_key(k);
    keys_sent++;
  endtask

  // A line of mostly printable text with some erasing, closed by a newline
  // or one of the signal keys.
  task automatic send_line();
    int               len;
    int               n;
    logic [KEY_W-1:0] k;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 28) : $urandom_range(12, 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 5) == 0) k = KEY_BS;
      else if ($urandom_range(0, 7) == 0) k = KEY_W'($urandom_range(255, 0));
      else k = KEY_W'($urandom_range(126, 32));
      send_key(k, n);
    end
    case ($urandom_range(0, 5))
      0, 1, 2: k = KEY_NL;
      3:       k = KEY_CTRL_C;
      4:       k = KEY_CTRL_Q;
      default: k = KEY_CTRL_Z;
    endcase
    send_key(k, n);
  endtask

  task automatic check_word();
    res_word_t got;
    res_word_t want;
    got.destination  = res_if.destination;
    got.data_byte    = res_if.data_byte;
    got.signal_kind  = res_if.signal_kind;
    got.signal_group = res_if.signal_group;
    got.last         = res_if.last;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected word dest=%0d data=%h kind=%0d group=%h last=%0d",
               $realtime, got.destination, got.data_byte, got.signal_kind,
               got.signal_group, got.last);
      error_count++;
    end else begin
      want = expected_words.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected dest=%0d data=%h kind=%0d group=%h last=%0d",
                 $realtime, want.destination, want.data_byte, want.signal_kind,
                 want.signal_group, want.last);
        $display("%0t:          actual   dest=%0d data=%h kind=%0d group=%h last=%0d",
                 $realtime, got.destination, got.data_byte, got.signal_kind,
                 got.signal_group, got.last);
        error_count++;
      end
    end
  endtask

  // Result side: random short stalls, plus one long hold-off on request.
  initial begin : res_sink
    int stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) check_word();
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD - 1;
        res_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left    = $urandom_range(3, 0);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin : main_seq
    dir_row_t         dir_rows [DIR_ROWS];
    int               n;
    int               phase_start;
    res_word_t        dropped;
    logic [KEY_W-1:0] k;
    logic             canon;
    logic [GROUP_W-1:0] group;

    error_count   = 0;
    keys_sent     = 0;
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    line_fill     = 0;
    cur_cfg.echo_enable    = 1'b1;
    cur_cfg.canonical_mode = 1'b1;
    cur_cfg.process_group  = '0;

    key_if.valid     <= 1'b0;
    key_if.key_byte  <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.reg_index <= '0;
    cfg_if.wr_data   <= '0;
    rst_n            <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    dir_rows = '{
      fixed_row(8'h61, 1'b1, DEST_ECHO),
      key_row(KEY_BS),
      fixed_row(KEY_BS, 1'b0, DEST_ECHO),   // erase on an empty line does nothing
      fixed_row(8'hFF, 1'b1, DEST_ECHO),
      fixed_row(8'h00, 1'b1, DEST_ECHO),
      key_row(KEY_NL),
      cfg_row(CFG_PROCESS_GROUP, 16'hFFFF),
      key_row(KEY_CTRL_C),
      key_row(8'h78),
      key_row(KEY_CTRL_Q),
      key_row(KEY_CTRL_Z),
      cfg_row(CFG_ECHO_ENABLE, 16'h0000),
      fixed_row(8'h71, 1'b0, DEST_ECHO),
      key_row(KEY_NL),
      cfg_row(CFG_PROCESS_GROUP, 16'h0000),
      cfg_row(CFG_CANONICAL_MODE, 16'h0000),
      fixed_row(KEY_BS, 1'b1, DEST_READER), // raw mode passes backspace through
      fixed_row(8'h41, 1'b1, DEST_READER),
      cfg_row(CFG_ECHO_ENABLE, 16'h0001),
      key_row(KEY_CTRL_Z),
      key_row(8'h80),
      cfg_row(CFG_ECHO_ENABLE, 16'hFFFE),   // only bit 0 is kept
      fixed_row(8'h7F, 1'b1, DEST_READER),
      cfg_row(CFG_UNUSED_IDX, 16'hFFFF),
      cfg_row(CFG_CANONICAL_MODE, 16'h0001),
      cfg_row(CFG_ECHO_ENABLE, 16'h0001),
      key_row(8'h55),
      key_row(KEY_CTRL_C)
    };

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        write_reg(dir_rows[r].reg_idx, dir_rows[r].value);
      end else begin
        send_key(dir_rows[r].value[KEY_W-1:0], n);
        if (dir_rows[r].kind == ROW_KEY_FIXED) begin
          repeat (n) dropped = expected_words.pop_back();
          if (dir_rows[r].fixed_count) expected_words.push_back(dir_rows[r].fixed_word);
        end
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 2))
        0:       group = '0;
        1:       group = '1;
        default: group = GROUP_W'($urandom_range(65535, 0));
      endcase
      case (phase)
        0: begin
          write_reg(CFG_ECHO_ENABLE, 16'h0001);
          write_reg(CFG_CANONICAL_MODE, 16'h0001);
        end
        1: begin
          write_reg(CFG_ECHO_ENABLE, 16'h0000);
          write_reg(CFG_CANONICAL_MODE, 16'h0001);
          group = '1;
        end
        2: begin
          write_reg(CFG_ECHO_ENABLE, 16'h0001);
          write_reg(CFG_CANONICAL_MODE, 16'h0000);
          group = '0;
        end
        3: begin
          write_reg(CFG_ECHO_ENABLE, 16'h0000);
          write_reg(CFG_CANONICAL_MODE, 16'h0000);
        end
        default: begin
          write_reg(CFG_ECHO_ENABLE, CFG_DATA_W'($urandom_range(1, 0)));
          write_reg(CFG_CANONICAL_MODE, ($urandom_range(0, 3) != 0) ? 16'h0001 : 16'h0000);
        end
      endcase
      write_reg(CFG_PROCESS_GROUP, group);
      canon   = cur_cfg.canonical_mode;
      idle_on = (phase < PHASES - 2);
      // The result side stops for a long while as this phase starts, so the
      // key side backs up behind a stalled flush.
      if (phase == 1) long_hold_req = 1'b1;
      phase_start = keys_sent;
      while (keys_sent - phase_start < PHASE_KEYS) begin
        if (canon && $urandom_range(0, 6) != 0) begin
          send_line();
        end else begin
          repeat ($urandom_range(3, 1)) begin
            k = KEY_W'($urandom_range(255, 0));
            send_key(k, n);
          end
        end
      end
    end

    settle();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #12ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
